// File: hw/rtl/isoep_pkg.sv
// Shared types, constants and calendar helpers for the ISO 8601 to epoch block.
// Depends on nothing; every other file of the block refers to it by scoped names.

package isoep_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_MIN_VALID_SECONDS = 2'd0;
    localparam logic [1:0] CFG_MIN_YEAR          = 2'd1;

    // Register reset values
    localparam logic [37:0] MIN_VALID_SECONDS_RST = 38'd1609459200;
    localparam logic [13:0] MIN_YEAR_RST          = 14'd2020;

    // Day count of 1970-01-01 on the internal day scale, in seconds
    localparam logic [38:0] EPOCH_SEC_OFFSET = 39'd74784816000;

    // Multiplier constants used by the shared unit
    localparam logic [16:0] RECIP_25       = 17'd1311;   // 2^15 / 25, rounded up
    localparam logic [16:0] YEARS_PER_CENT = 17'd100;
    localparam logic [16:0] DAYS_PER_YEAR  = 17'd365;
    localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
    localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
    localparam logic [16:0] MS_PER_SEC     = 17'd1000;
    localparam logic [13:0] YEAR_BIAS      = 14'd400;

    // Field limits
    localparam logic [6:0] MAX_HOUR   = 7'd23;
    localparam logic [6:0] MAX_MINUTE = 7'd59;
    localparam logic [6:0] MAX_SECOND = 7'd59;
    localparam logic [9:0] MAX_MILLIS = 10'd999;

    typedef enum logic [1:0] {
        PH_FIXED,
        PH_SEP,
        PH_FRAC,
        PH_END
    } phase_t;

    typedef enum logic [3:0] {
        CV_IDLE,
        CV_Y100,
        CV_R100,
        CV_C100,
        CV_DAYS,
        CV_TOD,
        CV_SECS,
        CV_MILL,
        CV_DONE
    } conv_state_t;

    // Parsed fields handed from the parser to the converter
    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [9:0]  millis;
    } fields_t;

    // Operands of the shared multiply-add unit: a * b + c
    typedef struct packed {
        logic [37:0] a;
        logic [16:0] b;
        logic [47:0] c;
    } mac_op_t;

    // Day of a March-based year on which a month starts
    function automatic logic [8:0] month_start(input logic [6:0] m);
        logic [8:0] r;
        begin
            case (m)
                7'd3:    r = 9'd0;
                7'd4:    r = 9'd31;
                7'd5:    r = 9'd61;
                7'd6:    r = 9'd92;
                7'd7:    r = 9'd122;
                7'd8:    r = 9'd153;
                7'd9:    r = 9'd184;
                7'd10:   r = 9'd214;
                7'd11:   r = 9'd245;
                7'd12:   r = 9'd275;
                7'd1:    r = 9'd306;
                7'd2:    r = 9'd337;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // Length of a month; zero for a month that does not exist
    function automatic logic [4:0] month_len(input logic [6:0] m, input logic leap);
        logic [4:0] r;
        begin
            case (m)
                7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: r = 5'd31;
                7'd4, 7'd6, 7'd9, 7'd11:                    r = 5'd30;
                7'd2:    r = leap ? 5'd29 : 5'd28;
                default: r = 5'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: hw/rtl/isoep_parser.sv
// Character parser: walks the timestamp text one character a word and gathers the fields.
// Depends on isoep_pkg.

module isoep_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          char_code,
    input  logic                last_char,
    output logic                start,
    output isoep_pkg::fields_t  snap
);

    localparam logic [4:0] POS_DASH1  = 5'd4;
    localparam logic [4:0] POS_DASH2  = 5'd7;
    localparam logic [4:0] POS_T      = 5'd10;
    localparam logic [4:0] POS_COLON1 = 5'd13;
    localparam logic [4:0] POS_COLON2 = 5'd16;
    localparam logic [4:0] POS_YEAR_END   = 5'd3;
    localparam logic [4:0] POS_MONTH_END  = 5'd6;
    localparam logic [4:0] POS_DAY_END    = 5'd9;
    localparam logic [4:0] POS_HOUR_END   = 5'd12;
    localparam logic [4:0] POS_MINUTE_END = 5'd15;
    localparam logic [4:0] FIXED_LENGTH   = 5'd19;

    logic [4:0]          pos_reg, pos_next;
    logic [13:0]         year_reg, year_next;
    logic [6:0]          month_reg, month_next;
    logic [6:0]          day_reg, day_next;
    logic [6:0]          hour_reg, hour_next;
    logic [6:0]          minute_reg, minute_next;
    logic [6:0]          second_reg, second_next;
    logic [9:0]          millis_reg, millis_next;
    logic [1:0]          frac_reg, frac_next;
    isoep_pkg::phase_t   phase_reg, phase_next;
    logic                err_reg, err_next;

    logic                dig;
    logic [3:0]          dval;
    logic [9:0]          ms_scaled;

    // Multiply by ten and add a digit, truncated to the field width
    function automatic logic [13:0] acc14(input logic [13:0] v, input logic [3:0] d);
        return (v << 3) + (v << 1) + {10'd0, d};
    endfunction

    function automatic logic [6:0] acc7(input logic [6:0] v, input logic [3:0] d);
        return (v << 3) + (v << 1) + {3'd0, d};
    endfunction

    function automatic logic [9:0] acc10(input logic [9:0] v, input logic [3:0] d);
        return (v << 3) + (v << 1) + {6'd0, d};
    endfunction

    assign dig  = (char_code >= 8'h30) && (char_code <= 8'h39);
    assign dval = dig ? 4'(char_code - 8'h30) : 4'd0;

    // Next parse state for the incoming character
    always_comb
    begin
        pos_next    = pos_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        millis_next = millis_reg;
        frac_next   = frac_reg;
        phase_next  = phase_reg;
        err_next    = err_reg;
        ms_scaled   = 10'd0;
        start       = 1'b0;
        snap        = '0;

        if (accept && !err_reg)
        begin
            case (phase_reg)
                isoep_pkg::PH_FIXED:
                begin
                    if (pos_reg == POS_DASH1 || pos_reg == POS_DASH2)
                        err_next = (char_code != 8'h2D);
                    else if (pos_reg == POS_T)
                        err_next = (char_code != 8'h54);
                    else if (pos_reg == POS_COLON1 || pos_reg == POS_COLON2)
                        err_next = (char_code != 8'h3A);
                    else if (!dig)
                        err_next = 1'b1;
                    else if (pos_reg <= POS_YEAR_END)
                        year_next = acc14(year_reg, dval);
                    else if (pos_reg <= POS_MONTH_END)
                        month_next = acc7(month_reg, dval);
                    else if (pos_reg <= POS_DAY_END)
                        day_next = acc7(day_reg, dval);
                    else if (pos_reg <= POS_HOUR_END)
                        hour_next = acc7(hour_reg, dval);
                    else if (pos_reg <= POS_MINUTE_END)
                        minute_next = acc7(minute_reg, dval);
                    else
                        second_next = acc7(second_reg, dval);

                    if (!err_next)
                    begin
                        pos_next = pos_reg + 5'd1;
                        if (pos_next >= FIXED_LENGTH)
                            phase_next = isoep_pkg::PH_SEP;
                    end
                end
                isoep_pkg::PH_SEP:
                begin
                    if (char_code == 8'h2E)
                        phase_next = isoep_pkg::PH_FRAC;
                    else if (char_code == 8'h5A)
                        phase_next = isoep_pkg::PH_END;
                    else
                        err_next = 1'b1;
                end
                isoep_pkg::PH_FRAC:
                begin
                    if (dig)
                    begin
                        if (frac_reg != 2'd3)
                        begin
                            millis_next = acc10(millis_reg, dval);
                            frac_next   = frac_reg + 2'd1;
                        end
                    end
                    else if (char_code == 8'h5A && frac_reg != 2'd0)
                        phase_next = isoep_pkg::PH_END;
                    else
                        err_next = 1'b1;
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase
        end

        // A short fraction is padded with zeros
        case (frac_next)
            2'd1:    ms_scaled = (millis_next << 6) + (millis_next << 5) + (millis_next << 2);
            2'd2:    ms_scaled = (millis_next << 3) + (millis_next << 1);
            default: ms_scaled = millis_next;
        endcase

        // On the last character, hand over the fields and clear for the next text
        if (accept && last_char)
        begin
            start       = 1'b1;
            snap.ok     = !err_next && (phase_next == isoep_pkg::PH_END);
            snap.year   = year_next;
            snap.month  = month_next;
            snap.day    = day_next;
            snap.hour   = hour_next;
            snap.minute = minute_next;
            snap.second = second_next;
            snap.millis = ms_scaled;

            pos_next    = 5'd0;
            year_next   = 14'd0;
            month_next  = 7'd0;
            day_next    = 7'd0;
            hour_next   = 7'd0;
            minute_next = 7'd0;
            second_next = 7'd0;
            millis_next = 10'd0;
            frac_next   = 2'd0;
            phase_next  = isoep_pkg::PH_FIXED;
            err_next    = 1'b0;
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 5'd0;
            year_reg   <= 14'd0;
            month_reg  <= 7'd0;
            day_reg    <= 7'd0;
            hour_reg   <= 7'd0;
            minute_reg <= 7'd0;
            second_reg <= 7'd0;
            millis_reg <= 10'd0;
            frac_reg   <= 2'd0;
            phase_reg  <= isoep_pkg::PH_FIXED;
            err_reg    <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            millis_reg <= millis_next;
            frac_reg   <= frac_next;
            phase_reg  <= phase_next;
            err_reg    <= err_next;
        end
    end

endmodule

// File: hw/rtl/isoep_mac.sv
// Shared multiply-add unit with a registered result: res = a * b + c.
// Depends on isoep_pkg.

module isoep_mac (
    input  logic               clk,
    input  logic               en,
    input  isoep_pkg::mac_op_t op,
    output logic [47:0]        res
);

    logic [54:0] prod;
    logic [47:0] res_reg, res_next;

    // One multiplication and one add, then the register
    always_comb
    begin
        prod     = {17'd0, op.a} * {38'd0, op.b};
        res_next = prod[47:0] + op.c;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// File: hw/rtl/isoep_conv.sv
// Conversion sequencer: drives the shared multiply-add unit through the calendar
// arithmetic, checks the field ranges and holds the result word. Depends on isoep_pkg, isoep_mac.

module isoep_conv (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  isoep_pkg::fields_t snap,
    input  logic [37:0]        min_valid_seconds,
    input  logic [13:0]        min_year,
    output logic               idle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [47:0]        out_data,
    output logic               out_user
);

    isoep_pkg::conv_state_t state_reg, state_next;
    isoep_pkg::fields_t     f_reg;
    logic [6:0]             qy_reg, qy_next;
    logic                   leap_reg, leap_next;
    logic [21:0]            days_reg, days_next;
    logic                   range_ok_reg, range_ok_next;
    logic                   out_valid_reg, out_valid_next;
    logic [47:0]            out_data_reg, out_data_next;
    logic                   out_user_reg, out_user_next;

    isoep_pkg::mac_op_t     op;
    logic                   mac_en;
    logic [47:0]            res;

    logic [13:0]            yy;
    logic [6:0]             c100;
    logic [15:0]            day_terms;
    logic [11:0]            min_sec;
    logic [38:0]            sp;
    logic [38:0]            sp_limit;
    logic                   fields_ok;
    logic                   load_out;

    isoep_mac u_mac (
        .clk (clk),
        .en  (mac_en),
        .op  (op),
        .res (res)
    );

    assign yy = f_reg.year + isoep_pkg::YEAR_BIAS
              - ((f_reg.month <= 7'd2) ? 14'd1 : 14'd0);
    assign c100      = res[21:15];
    assign day_terms = 16'(yy[13:2]) - 16'(c100) + 16'(c100[6:2])
                     + 16'(isoep_pkg::month_start(f_reg.month)) + 16'(f_reg.day) - 16'd1;
    assign min_sec   = {f_reg.minute, 5'd0} + {f_reg.minute, 5'd0}
                     - {3'd0, f_reg.minute, 2'd0} + {5'd0, f_reg.second};
    assign sp        = res[38:0];
    assign sp_limit  = isoep_pkg::EPOCH_SEC_OFFSET + {1'b0, min_valid_seconds};
    assign load_out  = (state_reg == isoep_pkg::CV_DONE) && (!out_valid_reg || out_ready);

    // Range checks on the captured fields
    always_comb
    begin
        fields_ok = f_reg.ok
                 && (f_reg.year >= min_year)
                 && (f_reg.day >= 7'd1)
                 && (f_reg.day <= {2'd0, isoep_pkg::month_len(f_reg.month, leap_reg)})
                 && (f_reg.hour <= isoep_pkg::MAX_HOUR)
                 && (f_reg.minute <= isoep_pkg::MAX_MINUTE)
                 && (f_reg.second <= isoep_pkg::MAX_SECOND)
                 && (f_reg.millis <= isoep_pkg::MAX_MILLIS)
                 && range_ok_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isoep_pkg::CV_IDLE: if (start) state_next = isoep_pkg::CV_Y100;
            isoep_pkg::CV_Y100: state_next = isoep_pkg::CV_R100;
            isoep_pkg::CV_R100: state_next = isoep_pkg::CV_C100;
            isoep_pkg::CV_C100: state_next = isoep_pkg::CV_DAYS;
            isoep_pkg::CV_DAYS: state_next = isoep_pkg::CV_TOD;
            isoep_pkg::CV_TOD:  state_next = isoep_pkg::CV_SECS;
            isoep_pkg::CV_SECS: state_next = isoep_pkg::CV_MILL;
            isoep_pkg::CV_MILL: state_next = isoep_pkg::CV_DONE;
            isoep_pkg::CV_DONE: if (load_out) state_next = isoep_pkg::CV_IDLE;
            default:            state_next = isoep_pkg::CV_IDLE;
        endcase
    end

    // Operand selection for the shared unit and the working registers
    always_comb
    begin
        op            = '0;
        mac_en        = 1'b0;
        qy_next       = qy_reg;
        leap_next     = leap_reg;
        days_next     = days_reg;
        range_ok_next = range_ok_reg;
        case (state_reg)
            isoep_pkg::CV_Y100:
            begin
                // year / 100 through a reciprocal of 25 on year / 4
                mac_en = 1'b1;
                op.a   = 38'(f_reg.year[13:2]);
                op.b   = isoep_pkg::RECIP_25;
            end
            isoep_pkg::CV_R100:
            begin
                mac_en  = 1'b1;
                qy_next = res[21:15];
                op.a    = 38'(res[21:15]);
                op.b    = isoep_pkg::YEARS_PER_CENT;
            end
            isoep_pkg::CV_C100:
            begin
                // Leap year from the remainder by 100 and the century count
                leap_next = (f_reg.year[1:0] == 2'd0)
                         && ((res[13:0] != f_reg.year) || (qy_reg[1:0] == 2'd0));
                mac_en = 1'b1;
                op.a   = 38'(yy[13:2]);
                op.b   = isoep_pkg::RECIP_25;
            end
            isoep_pkg::CV_DAYS:
            begin
                mac_en = 1'b1;
                op.a   = 38'(yy);
                op.b   = isoep_pkg::DAYS_PER_YEAR;
                op.c   = 48'(day_terms);
            end
            isoep_pkg::CV_TOD:
            begin
                days_next = res[21:0];
                mac_en    = 1'b1;
                op.a      = 38'(f_reg.hour);
                op.b      = isoep_pkg::SECS_PER_HOUR;
                op.c      = 48'(min_sec);
            end
            isoep_pkg::CV_SECS:
            begin
                mac_en = 1'b1;
                op.a   = 38'(days_reg);
                op.b   = isoep_pkg::SECS_PER_DAY;
                op.c   = res;
            end
            isoep_pkg::CV_MILL:
            begin
                // Reject anything before the epoch or before the earliest accepted time
                range_ok_next = (sp >= sp_limit);
                mac_en        = 1'b1;
                op.a          = 38'(sp - isoep_pkg::EPOCH_SEC_OFFSET);
                op.b          = isoep_pkg::MS_PER_SEC;
                op.c          = 48'(f_reg.millis);
            end
            default:
            begin
                mac_en = 1'b0;
            end
        endcase
    end

    // Output word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_user_next  = fields_ok;
            out_data_next  = fields_ok ? res : 48'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isoep_pkg::CV_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (start && state_reg == isoep_pkg::CV_IDLE)
            f_reg <= snap;
        qy_reg       <= qy_next;
        leap_reg     <= leap_next;
        days_reg     <= days_next;
        range_ok_reg <= range_ok_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign idle      = (state_reg == isoep_pkg::CV_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

    // A new text is only handed over while the sequencer is free
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == isoep_pkg::CV_IDLE)
        else $error("conversion started while busy");

    // A result word appears only after the final sequencer step
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == isoep_pkg::CV_DONE)
        else $error("result word loaded outside the final step");

    // A rejected text always reports zero milliseconds
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_user_reg |-> out_data_reg == 48'd0)
        else $error("rejected text carries a non-zero value");

    // The day sum always follows the leap-year step
    a_days_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == isoep_pkg::CV_DAYS |-> $past(state_reg) == isoep_pkg::CV_C100)
        else $error("sequencer skipped the leap-year step");

endmodule

// File: hw/rtl/iso8601_utc_to_epoch_ms.sv
// ISO 8601 UTC timestamp to Unix epoch milliseconds converter.
//
// Input stream: one character of YYYY-MM-DDTHH:MM:SS[.fff...]Z per word,
// s_axis_tlast on the last one. Characters are taken one a cycle while idle.
// Output stream: one word per text, m_axis_tuser set when the text parsed
// and passed every check, m_axis_tdata the milliseconds (zero otherwise).
// Configuration: cfg_we with cfg_index 0 writes the earliest accepted time
// in seconds, index 1 the smallest accepted year; other indexes are ignored.
// The conversion runs 7 multiply-add steps on one shared unit, and
// s_axis_tready is low from each last character until the result word is
// loaded, so no new text is taken while a conversion runs.
// Reset clears the parser and output, and restores the register defaults
// (1609459200 seconds, year 2020). If the receiver stalls, the result word
// is held; characters of the next text, its last one included, keep being
// taken, but its conversion then waits in the final step, with
// s_axis_tready low, until the previous word has been delivered.
// Depends on isoep_pkg, isoep_parser, isoep_conv and isoep_mac.

module iso8601_utc_to_epoch_ms (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [47:0] epoch_millis
    output logic        m_axis_tuser,   // [0] valid_res
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [37:0] cfg_data
);

    logic [37:0]        min_valid_reg;
    logic [13:0]        min_year_reg;
    logic               accept;
    logic               start;
    logic               conv_idle;
    isoep_pkg::fields_t snap;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_valid_reg <= isoep_pkg::MIN_VALID_SECONDS_RST;
            min_year_reg  <= isoep_pkg::MIN_YEAR_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == isoep_pkg::CFG_MIN_VALID_SECONDS)
                min_valid_reg <= cfg_data;
            else if (cfg_index == isoep_pkg::CFG_MIN_YEAR)
                min_year_reg <= cfg_data[13:0];
        end
    end

    assign s_axis_tready = conv_idle;
    assign accept        = s_axis_tvalid && s_axis_tready;

    isoep_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (s_axis_tdata),
        .last_char (s_axis_tlast),
        .start     (start),
        .snap      (snap)
    );

    isoep_conv u_conv (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .snap              (snap),
        .min_valid_seconds (min_valid_reg),
        .min_year          (min_year_reg),
        .idle              (conv_idle),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_data          (m_axis_tdata),
        .out_user          (m_axis_tuser)
    );

endmodule

// File: bench/iso8601_utc_to_epoch_ms_test.sv
// Self-checking bench for the ISO 8601 timestamp to epoch milliseconds converter.
// Drives text one character per word, predicts each result word and compares them.
// Depends on isoep_pkg and iso8601_utc_to_epoch_ms.

module iso8601_utc_to_epoch_ms_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Character codes of the timestamp grammar
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_DASH  = "-";
    localparam logic [7:0] CH_T     = "T";
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_Z     = "Z";

    // Register indexes that the block does not implement
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [37:0] SECONDS_FLOOR_RST = 38'd1609459200;
    localparam logic [13:0] YEAR_FLOOR_RST    = 14'd2020;
    localparam logic [37:0] SECONDS_FLOOR_MAX = 38'd253402300799;
    localparam int          FIXED_CHARS       = 19;
    localparam int          SETTLE_CYCLES     = 20;
    localparam int          DIR_N             = 25;

    typedef struct packed {
        logic        ok;
        logic [47:0] millis;
    } stamp_result_t;

    typedef struct {
        string       text;
        bit          typed;
        bit          ok;
        logic [47:0] millis;
    } dir_row_t;

    // Directed texts; rows with typed set carry a result that is obvious by eye
    dir_row_t dir_rows [DIR_N] = '{
        '{"2021-01-01T00:00:00Z",        1'b1, 1'b1, 48'd1609459200000},
        '{"2021-01-01T00:00:00.5Z",      1'b0, 1'b0, 48'd0},
        '{"2021-01-01T00:00:00.12Z",     1'b0, 1'b0, 48'd0},
        '{"2021-01-01T00:00:00.123456Z", 1'b0, 1'b0, 48'd0},
        '{"2020-12-31T23:59:59.999Z",    1'b1, 1'b0, 48'd0},
        '{"2021-01-01T00:00:00.Z",       1'b1, 1'b0, 48'd0},
        '{"2021-01-01T00:00:00",         1'b1, 1'b0, 48'd0},
        '{"2021-01-01T00:00:00ZZ",       1'b1, 1'b0, 48'd0},
        '{"2021-01-01 00:00:00Z",        1'b1, 1'b0, 48'd0},
        '{"9999-12-31T23:59:59.999Z",    1'b1, 1'b1, 48'd253402300799999},
        '{"2024-02-29T12:00:00Z",        1'b0, 1'b0, 48'd0},
        '{"2023-02-29T12:00:00Z",        1'b1, 1'b0, 48'd0},
        '{"2100-02-29T00:00:00Z",        1'b1, 1'b0, 48'd0},
        '{"2019-06-15T00:00:00Z",        1'b1, 1'b0, 48'd0},
        '{"2400-02-29T23:59:59Z",        1'b0, 1'b0, 48'd0},
        '{"2021-13-01T00:00:00Z",        1'b1, 1'b0, 48'd0},
        '{"2021-04-31T00:00:00Z",        1'b1, 1'b0, 48'd0},
        '{"2021-01-00T00:00:00Z",        1'b1, 1'b0, 48'd0},
        '{"2021-01-01T24:00:00Z",        1'b1, 1'b0, 48'd0},
        '{"2021-01-01T23:60:00Z",        1'b1, 1'b0, 48'd0},
        '{"2021-01-01T23:59:60Z",        1'b1, 1'b0, 48'd0},
        '{"Z",                           1'b1, 1'b0, 48'd0},
        '{"2021-01-01T00:00:00+Z",       1'b1, 1'b0, 48'd0},
        '{"2021-01-01T00:00:00.1a2Z",    1'b1, 1'b0, 48'd0},
        '{"2021-12-31T23:59:59.9999Z",   1'b0, 1'b0, 48'd0}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] char_code
    logic        s_axis_tlast  = 1'b0;   // last_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;           // [47:0] epoch_millis
    logic        m_axis_tuser;           // [0] valid_res
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = 2'd0;
    logic [37:0] cfg_data      = 38'd0;

    // Predicted parser state and register copies
    logic [37:0]         floor_seconds;
    logic [13:0]         floor_year;
    logic [4:0]          text_pos;
    logic [13:0]         year_acc;
    logic [6:0]          month_acc;
    logic [6:0]          day_acc;
    logic [6:0]          hour_acc;
    logic [6:0]          minute_acc;
    logic [6:0]          second_acc;
    logic [9:0]          fraction_acc;
    logic [1:0]          fraction_count;
    isoep_pkg::phase_t   text_phase;
    logic                text_broken;

    stamp_result_t pending_stamps[$];
    logic [7:0]    stamp_text[$];
    int            stamps_done = 0;
    int            mismatches  = 0;
    int            ready_left  = 0;
    logic          steady      = 1'b0;
    int            gen_min_year;

    iso8601_utc_to_epoch_ms uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit, far beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic clear_text_state();
        text_pos       = 5'd0;
        year_acc       = 14'd0;
        month_acc      = 7'd0;
        day_acc        = 7'd0;
        hour_acc       = 7'd0;
        minute_acc     = 7'd0;
        second_acc     = 7'd0;
        fraction_acc   = 10'd0;
        fraction_count = 2'd0;
        text_phase     = isoep_pkg::PH_FIXED;
        text_broken    = 1'b0;
    endtask

    // Days in a month of the Gregorian calendar; zero for a month that does not exist
    function automatic int days_in_month(input longint y, input longint m);
        logic leap;
        int   n;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (m)
            1, 3, 5, 7, 8, 10, 12: n = 31;
            4, 6, 9, 11:           n = 30;
            2:                     n = leap ? 29 : 28;
            default:               n = 0;
        endcase
        return n;
    endfunction

    // Advances the parse by one accepted character and queues the result word on the last one
    task automatic predict_char(input logic [7:0] c, input logic last);
        logic          is_dig;
        logic          ok;
        int            dv;
        int            ms;
        longint        y, m, d, yy, era, yoe, mp, doy, doe, secs;
        stamp_result_t res;
        is_dig = (c >= CH_0) && (c <= CH_9);
        dv     = is_dig ? int'(c - CH_0) : 0;
        if (!text_broken)
        begin
            case (text_phase)
                isoep_pkg::PH_FIXED:
                begin
                    ok = 1'b1;
                    if (text_pos == 5'd4 || text_pos == 5'd7) ok = (c == CH_DASH);
                    else if (text_pos == 5'd10) ok = (c == CH_T);
                    else if (text_pos == 5'd13 || text_pos == 5'd16) ok = (c == CH_COLON);
                    else if (!is_dig) ok = 1'b0;
                    else if (text_pos <= 5'd3) year_acc = 14'(int'(year_acc) * 10 + dv);
                    else if (text_pos <= 5'd6) month_acc = 7'(int'(month_acc) * 10 + dv);
                    else if (text_pos <= 5'd9) day_acc = 7'(int'(day_acc) * 10 + dv);
                    else if (text_pos <= 5'd12) hour_acc = 7'(int'(hour_acc) * 10 + dv);
                    else if (text_pos <= 5'd15) minute_acc = 7'(int'(minute_acc) * 10 + dv);
                    else second_acc = 7'(int'(second_acc) * 10 + dv);
                    if (!ok)
                        text_broken = 1'b1;
                    else
                    begin
                        text_pos = text_pos + 5'd1;
                        if (int'(text_pos) >= FIXED_CHARS) text_phase = isoep_pkg::PH_SEP;
                    end
                end
                isoep_pkg::PH_SEP:
                begin
                    if (c == CH_DOT) text_phase = isoep_pkg::PH_FRAC;
                    else if (c == CH_Z) text_phase = isoep_pkg::PH_END;
                    else text_broken = 1'b1;
                end
                isoep_pkg::PH_FRAC:
                begin
                    // Digits past the third are taken but do not count
                    if (is_dig)
                    begin
                        if (fraction_count < 2'd3)
                        begin
                            fraction_acc   = 10'(int'(fraction_acc) * 10 + dv);
                            fraction_count = fraction_count + 2'd1;
                        end
                    end
                    else if (c == CH_Z && fraction_count != 2'd0)
                        text_phase = isoep_pkg::PH_END;
                    else
                        text_broken = 1'b1;
                end
                default:
                    text_broken = 1'b1;
            endcase
        end
        if (last)
        begin
            ok = !text_broken && (text_phase == isoep_pkg::PH_END);
            ms = int'(fraction_acc);
            if (text_phase == isoep_pkg::PH_END && fraction_count == 2'd1) ms = ms * 100;
            else if (text_phase == isoep_pkg::PH_END && fraction_count == 2'd2) ms = ms * 10;
            y = longint'(year_acc);
            m = longint'(month_acc);
            d = longint'(day_acc);
            res.millis = 48'd0;
            if (ok)
            begin
                if (year_acc < floor_year) ok = 1'b0;
                if (d < 1 || d > days_in_month(y, m)) ok = 1'b0;
                if (hour_acc > 7'd23 || minute_acc > 7'd59 || second_acc > 7'd59) ok = 1'b0;
                if (ms > 999) ok = 1'b0;
            end
            if (ok)
            begin
                // Day count from a March-based year, shifted by one era to stay positive
                yy   = y - ((m <= 2) ? 1 : 0) + 400;
                era  = yy / 400;
                yoe  = yy - era * 400;
                mp   = (m > 2) ? m - 3 : m + 9;
                doy  = (153 * mp + 2) / 5 + d - 1;
                doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
                secs = (era * 146097 + doe - 719468 - 146097) * 86400
                     + longint'(hour_acc) * 3600 + longint'(minute_acc) * 60
                     + longint'(second_acc);
                if (secs < 0 || secs < longint'(floor_seconds))
                    ok = 1'b0;
                else
                    res.millis = 48'(secs * 1000 + longint'(ms));
            end
            res.ok = ok;
            if (stamps_done < DIR_N && dir_rows[stamps_done].typed)
            begin
                res.ok     = dir_rows[stamps_done].ok;
                res.millis = dir_rows[stamps_done].millis;
            end
            pending_stamps.push_back(res);
            stamps_done++;
            clear_text_state();
        end
    endtask

    // Observes every handshake: result words, register writes and characters
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            floor_seconds = SECONDS_FLOOR_RST;
            floor_year    = YEAR_FLOOR_RST;
            clear_text_state();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_stamps.size() == 0)
                begin
                    $error("unexpected result word: valid_res %0d, epoch_millis %0d",
                           m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    if (m_axis_tuser !== pending_stamps[0].ok)
                    begin
                        $error("valid_res: expected %0d, got %0d",
                               pending_stamps[0].ok, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata !== pending_stamps[0].millis)
                    begin
                        $error("epoch_millis: expected %0d, got %0d",
                               pending_stamps[0].millis, m_axis_tdata);
                        mismatches++;
                    end
                    void'(pending_stamps.pop_front());
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == isoep_pkg::CFG_MIN_VALID_SECONDS) floor_seconds = cfg_data;
                else if (cfg_index == isoep_pkg::CFG_MIN_YEAR) floor_year = cfg_data[13:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_char(s_axis_tdata, s_axis_tlast);
        end
    end

    // Receiver: ready in random runs, stalled in bursts of random length
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_left    <= 0;
        end
        else if (steady)
            m_axis_tready <= 1'b1;
        else if (ready_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                ready_left    <= $urandom_range(1, 8);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                ready_left    <= $urandom_range(1, ($urandom_range(0, 7) == 0) ? 200 : 20);
            end
        end
        else
            ready_left <= ready_left - 1;
    end

    // One character word, then now and then a gap of random length
    task automatic send_char(input logic [7:0] c, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic send_stamp();
        foreach (stamp_text[i])
            send_char(stamp_text[i], i == stamp_text.size() - 1);
    endtask

    // Holds the sender until every result word has come back and the block has settled
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_stamps.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [37:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic put_digits(input int value, input int width);
        int div;
        div = 1;
        repeat (width - 1) div = div * 10;
        while (div > 0)
        begin
            stamp_text.push_back(8'(int'(CH_0) + (value / div) % 10));
            div = div / 10;
        end
    endtask

    // Builds one random text: mostly well formed, the rest damaged or noise.
    task automatic build_stamp();
        int pick, yr, mo, dy, hr, mi, sc, nf, cut;
        stamp_text.delete();
        pick = $urandom_range(0, 9);
        if (pick < 5) yr = $urandom_range(1970, 2100);
        else if (pick < 7 && gen_min_year <= 9999)
            yr = gen_min_year + $urandom_range(0, 2) - ((gen_min_year > 0) ? 1 : 0);
        else if (pick < 8) yr = 9999;
        else yr = $urandom_range(0, 9999);
        if (yr > 9999) yr = 9999;
        mo = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 99);
        dy = ($urandom_range(0, 7) != 0) ? $urandom_range(1, 31) : $urandom_range(0, 99);
        hr = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 23) : $urandom_range(24, 99);
        mi = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(60, 99);
        sc = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(60, 99);
        // Last second of the calendar range, to meet the highest floors
        if (yr == 9999 && $urandom_range(0, 1) == 0)
        begin
            mo = 12; dy = 31; hr = 23; mi = 59; sc = 59;
        end
        put_digits(yr, 4);
        stamp_text.push_back(CH_DASH);
        put_digits(mo, 2);
        stamp_text.push_back(CH_DASH);
        put_digits(dy, 2);
        stamp_text.push_back(CH_T);
        put_digits(hr, 2);
        stamp_text.push_back(CH_COLON);
        put_digits(mi, 2);
        stamp_text.push_back(CH_COLON);
        put_digits(sc, 2);
        nf = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        if (nf > 0)
        begin
            stamp_text.push_back(CH_DOT);
            repeat (nf) stamp_text.push_back(8'(int'(CH_0) + $urandom_range(0, 9)));
        end
        stamp_text.push_back(CH_Z);
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    cut = $urandom_range(0, stamp_text.size() - 1);
                    stamp_text[cut] = 8'($urandom_range(0, 255));
                end
                1:
                begin
                    cut = $urandom_range(1, stamp_text.size() - 1);
                    while (stamp_text.size() > cut) void'(stamp_text.pop_back());
                end
                2:
                    repeat ($urandom_range(1, 3))
                        stamp_text.push_back(8'($urandom_range(0, 255)));
                default:
                begin
                    stamp_text.delete();
                    repeat ($urandom_range(1, 30))
                        stamp_text.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // Sends random texts until about budget characters have gone out
    task automatic run_random(input int budget);
        int counted;
        counted = 0;
        while (counted < budget)
        begin
            build_stamp();
            send_stamp();
            counted += stamp_text.size();
        end
        wait_idle();
    endtask

    task automatic set_floors(input logic [37:0] seconds, input int year);
        write_reg(isoep_pkg::CFG_MIN_VALID_SECONDS, seconds);
        write_reg(isoep_pkg::CFG_MIN_YEAR, 38'(year));
        gen_min_year = year;
    endtask

    // Main sequence
    initial
    begin
        gen_min_year = int'(YEAR_FLOOR_RST);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts at the reset register values
        foreach (dir_rows[r])
        begin
            stamp_text.delete();
            for (int i = 0; i < dir_rows[r].text.len(); i++)
                stamp_text.push_back(dir_rows[r].text[i]);
            send_stamp();
        end
        wait_idle();

        run_random(330);

        // Lowest floors
        set_floors(38'd0, 1970);
        run_random(330);

        // Highest floors: only the last second of year 9999 can pass
        set_floors(SECONDS_FLOOR_MAX, 9999);
        run_random(140);

        // Year floor above 9999, so nothing is valid; spare indexes must be ignored
        set_floors(38'd0, 16383);
        write_reg(CFG_SPARE_2, 38'({$urandom, $urandom}));
        write_reg(CFG_SPARE_3, 38'({$urandom, $urandom}));
        run_random(140);

        // Random floors, the last stretch without any idling
        set_floors(38'($urandom_range(0, 32'd4102444800)), $urandom_range(1970, 2100));
        run_random(180);
        set_floors(38'($urandom_range(0, 32'd4102444800)), $urandom_range(1970, 2100));
        steady <= 1'b1;
        run_random(180);

        if (mismatches == 0 && pending_stamps.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
